// File: src/tcwc_pkg.sv
// Shared types, constants and helpers of the TCP congestion window controller.
`default_nettype none

package tcwc_pkg;

  localparam int unsigned FracBits = 16;
  localparam int unsigned QuoW     = 2 * FracBits + 1;
  localparam int unsigned CntW     = $clog2(QuoW);

  localparam logic [31:0] FxOne    = 32'(64'(1) << FracBits);
  localparam logic [31:0] FxTwo    = 32'(64'(2) << FracBits);
  localparam logic [31:0] FxThree  = 32'(64'(3) << FracBits);
  localparam logic [31:0] FxSixteen = 32'(64'(16) << FracBits);

  typedef enum logic [1:0] {
    FuncAck     = 2'd0,
    FuncDupAck  = 2'd1,
    FuncTimeout = 2'd2,
    FuncNone    = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    AlgTahoe   = 2'd0,
    AlgReno    = 2'd1,
    AlgNewReno = 2'd2,
    AlgSpare   = 2'd3
  } alg_e;

  typedef enum logic [1:0] {
    PhSlowStart = 2'd0,
    PhAvoid     = 2'd1,
    PhRecovery  = 2'd2,
    PhSpare     = 2'd3
  } phase_e;

  typedef enum logic [3:0] {
    ExDupWait   = 4'd0,
    ExSsGrow    = 4'd1,
    ExCaGrow    = 4'd2,
    ExPartial   = 4'd3,
    ExFullExit  = 4'd4,
    ExTahoe     = 4'd5,
    ExRenoFr    = 4'd6,
    ExNewRenoFr = 4'd7,
    ExTimeout   = 4'd8
  } expl_e;

  // Saturating add of a 33-bit increment to a 32-bit window.
  function automatic logic [31:0] sat_add(logic [31:0] a, logic [32:0] b);
    logic [33:0] s;
    s = {2'b00, a} + {1'b0, b};
    return (|s[33:32]) ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // Halve the window with a floor of 2.0.
  function automatic logic [31:0] cut_thresh(logic [31:0] w);
    logic [31:0] h;
    h = w >> 1;
    return (h < FxTwo) ? FxTwo : h;
  endfunction

endpackage

`default_nettype wire

// File: src/tcp_congestion_window_control.sv
// Top level of the TCP congestion window controller (Tahoe, Reno, NewReno).
//
//  channel | signals                                   | direction
//  config  | cfg_we_i, cfg_wdata_i                     | in, written without wait
//  event   | in_valid_i/in_ready_o, func_i, ack_number_i | in
//  result  | out_valid_o/out_ready_i, window_o .. explanation_o | out
//
// A new ACK in congestion avoidance first runs the radix-2 restoring divider that
// forms the reciprocal increase, then commits; every other event goes straight to commit.
// An unused event code is taken and dropped.
// Reset brings window 1.0, threshold 16.0, slow start and the Reno variant.
// A word whose result is not yet taken holds the commit of the next word.
`default_nettype none

module tcp_congestion_window_control (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  func_i,
  input  wire logic [30:0] ack_number_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      window_o,
  output logic [31:0]      threshold_o,
  output logic [1:0]       phase_o,
  output logic [31:0]      event_count_o,
  output logic [3:0]       explanation_o
);

  typedef enum logic [1:0] {
    StIdle   = 2'd0,
    StDiv    = 2'd1,
    StCommit = 2'd2
  } state_e;

  state_e state_q, state_d;

  logic [1:0]  alg_q, alg_d;
  logic [1:0]  phase_q, phase_d;
  logic [31:0] cwnd_q, cwnd_d;
  logic [31:0] ssth_q, ssth_d;
  logic [1:0]  dup_q, dup_d;
  logic [31:0] events_q, events_d;
  logic [31:0] recov_q, recov_d;

  logic [1:0]  func_q, func_d;
  logic [30:0] ack_q, ack_d;

  logic [31:0]               rem_q, rem_d;
  logic [tcwc_pkg::QuoW-1:0] quo_q, quo_d;
  logic [tcwc_pkg::CntW-1:0] cnt_q, cnt_d;

  logic        out_valid_q, out_valid_d;
  logic [31:0] win_out_q, win_out_d;
  logic [31:0] thr_out_q, thr_out_d;
  logic [1:0]  ph_out_q, ph_out_d;
  logic [31:0] ev_out_q, ev_out_d;
  logic [3:0]  ex_out_q, ex_out_d;

  logic        in_fire;
  logic        commit;
  logic [32:0] rem_shift;
  logic        rem_ge;
  logic [63:0] quo_wide;
  logic [32:0] ca_inc;
  logic [31:0] ss_win;
  logic [31:0] cut;
  logic [1:0]  dup_next;
  logic [3:0]  expl;

  assign in_ready_o = (state_q == StIdle);
  assign in_fire    = in_valid_i && in_ready_o;
  assign commit     = (state_q == StCommit) && (!out_valid_q || out_ready_i);

  assign rem_shift = {rem_q, (cnt_q == tcwc_pkg::CntW'(2 * tcwc_pkg::FracBits))};
  assign rem_ge    = rem_shift >= {1'b0, cwnd_q};
  assign quo_wide  = 64'(quo_q);
  assign ca_inc    = (cwnd_q == 32'd0 || (|quo_wide[63:33])) ? {33{1'b1}} : quo_wide[32:0];
  assign ss_win    = tcwc_pkg::sat_add(cwnd_q, {1'b0, tcwc_pkg::FxOne});
  assign cut       = tcwc_pkg::cut_thresh(cwnd_q);
  assign dup_next  = (dup_q == 2'd3) ? 2'd3 : dup_q + 2'd1;

  always_comb begin
    state_d     = state_q;
    alg_d       = cfg_we_i ? cfg_wdata_i : alg_q;
    phase_d     = phase_q;
    cwnd_d      = cwnd_q;
    ssth_d      = ssth_q;
    dup_d       = dup_q;
    events_d    = events_q;
    recov_d     = recov_q;
    func_d      = func_q;
    ack_d       = ack_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    win_out_d   = win_out_q;
    thr_out_d   = thr_out_q;
    ph_out_d    = ph_out_q;
    ev_out_d    = ev_out_q;
    ex_out_d    = ex_out_q;
    expl        = tcwc_pkg::ExDupWait;

    case (state_q)
      StIdle: begin
        if (in_fire && func_i != tcwc_pkg::FuncNone) begin
          func_d = func_i;
          ack_d  = ack_number_i;
          rem_d  = 32'd0;
          quo_d  = '0;
          cnt_d  = tcwc_pkg::CntW'(tcwc_pkg::QuoW - 1);
          if (func_i == tcwc_pkg::FuncAck && phase_q == tcwc_pkg::PhAvoid &&
              cwnd_q != 32'd0) begin
            state_d = StDiv;
          end else begin
            state_d = StCommit;
          end
        end
      end
      StDiv: begin
        rem_d = rem_ge ? 32'(rem_shift - {1'b0, cwnd_q}) : rem_shift[31:0];
        quo_d = {quo_q[tcwc_pkg::QuoW-2:0], rem_ge};
        cnt_d = cnt_q - tcwc_pkg::CntW'(1);
        if (cnt_q == '0) begin
          state_d = StCommit;
        end
      end
      StCommit: begin
        if (commit) begin
          events_d = events_q + 32'd1;
          case (func_q)
            tcwc_pkg::FuncAck: begin
              dup_d = 2'd0;
              case (phase_q)
                tcwc_pkg::PhSlowStart: begin
                  cwnd_d = ss_win;
                  if (ss_win >= ssth_q) begin
                    phase_d = tcwc_pkg::PhAvoid;
                  end
                  expl = tcwc_pkg::ExSsGrow;
                end
                tcwc_pkg::PhAvoid: begin
                  cwnd_d = tcwc_pkg::sat_add(cwnd_q, ca_inc);
                  expl   = tcwc_pkg::ExCaGrow;
                end
                default: begin
                  if (alg_q == tcwc_pkg::AlgNewReno && {1'b0, ack_q} < recov_q) begin
                    cwnd_d = ss_win;
                    expl   = tcwc_pkg::ExPartial;
                  end else begin
                    cwnd_d  = ssth_q;
                    phase_d = tcwc_pkg::PhAvoid;
                    expl    = tcwc_pkg::ExFullExit;
                  end
                end
              endcase
            end
            tcwc_pkg::FuncDupAck: begin
              dup_d = dup_next;
              if (dup_next == 2'd3) begin
                ssth_d = cut;
                if (alg_q == tcwc_pkg::AlgTahoe) begin
                  cwnd_d  = tcwc_pkg::FxOne;
                  phase_d = tcwc_pkg::PhSlowStart;
                  expl    = tcwc_pkg::ExTahoe;
                end else begin
                  if (alg_q == tcwc_pkg::AlgNewReno) begin
                    recov_d = {1'b0, ack_q} + 32'(cwnd_q >> tcwc_pkg::FracBits);
                    expl    = tcwc_pkg::ExNewRenoFr;
                  end else begin
                    expl = tcwc_pkg::ExRenoFr;
                  end
                  cwnd_d  = tcwc_pkg::sat_add(cut, {1'b0, tcwc_pkg::FxThree});
                  phase_d = tcwc_pkg::PhRecovery;
                end
              end
            end
            default: begin
              ssth_d  = cut;
              cwnd_d  = tcwc_pkg::FxOne;
              dup_d   = 2'd0;
              phase_d = tcwc_pkg::PhSlowStart;
              expl    = tcwc_pkg::ExTimeout;
            end
          endcase
          out_valid_d = 1'b1;
          win_out_d   = cwnd_d;
          thr_out_d   = ssth_d;
          ph_out_d    = phase_d;
          ev_out_d    = events_d;
          ex_out_d    = expl;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      alg_q       <= tcwc_pkg::AlgReno;
      phase_q     <= tcwc_pkg::PhSlowStart;
      cwnd_q      <= tcwc_pkg::FxOne;
      ssth_q      <= tcwc_pkg::FxSixteen;
      dup_q       <= 2'd0;
      events_q    <= 32'd0;
      recov_q     <= 32'd0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      alg_q       <= alg_d;
      phase_q     <= phase_d;
      cwnd_q      <= cwnd_d;
      ssth_q      <= ssth_d;
      dup_q       <= dup_d;
      events_q    <= events_d;
      recov_q     <= recov_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q    <= func_d;
    ack_q     <= ack_d;
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    win_out_q <= win_out_d;
    thr_out_q <= thr_out_d;
    ph_out_q  <= ph_out_d;
    ev_out_q  <= ev_out_d;
    ex_out_q  <= ex_out_d;
  end

  assign out_valid_o   = out_valid_q;
  assign window_o      = win_out_q;
  assign threshold_o   = thr_out_q;
  assign phase_o       = ph_out_q;
  assign event_count_o = ev_out_q;
  assign explanation_o = ex_out_q;

`ifndef NO_ASSERTIONS
  a_window_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cwnd_q >= tcwc_pkg::FxOne)
    else $error("Congestion window fell below one packet.");

  a_thresh_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ssth_q >= tcwc_pkg::FxTwo)
    else $error("Slow-start threshold fell below two packets.");

  a_phase_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != tcwc_pkg::PhSpare)
    else $error("Phase register holds an unused code.");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv && cnt_q == '0) |=> (state_q == StCommit && quo_q != '0))
    else $error("Divider did not hand a nonzero increment to the commit step.");

  a_event_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> (events_q == $past(events_q) + 32'd1 && out_valid_q))
    else $error("Commit did not count the event or present a result.");
`endif

endmodule

`default_nettype wire

// File: test/tcwc_window_checker.sv
// Checker that predicts every result word of the congestion window controller and compares it.
`timescale 1ns / 1ps

module tcwc_window_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_wdata_i,
  input  wire logic        in_valid_i,
  input  wire logic        in_ready_i,
  input  wire logic [1:0]  func_i,
  input  wire logic [30:0] ack_number_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_ready_i,
  input  wire logic [31:0] window_i,
  input  wire logic [31:0] threshold_i,
  input  wire logic [1:0]  phase_i,
  input  wire logic [31:0] event_count_i,
  input  wire logic [3:0]  explanation_i,
  output int               fail_count_o,
  output int               pending_o,
  output int               checked_o,
  output logic [8:0]       expl_seen_o
);

  typedef struct packed {
    logic [31:0]      window;
    logic [31:0]      threshold;
    tcwc_pkg::phase_e phase;
    logic [31:0]      event_count;
    tcwc_pkg::expl_e  explanation;
  } cw_result_t;

  localparam logic [63:0] OneWide = 64'd1 << tcwc_pkg::FracBits;

  cw_result_t       predicted_q[$];
  tcwc_pkg::alg_e   variant;
  tcwc_pkg::phase_e cur_phase;
  logic [31:0]      cwnd;
  logic [31:0]      ssthresh;
  logic [31:0]      events;
  logic [31:0]      recover_pt;
  logic [1:0]       dups;
  int               fails;
  int               checked;
  logic [8:0]       seen;

  function automatic logic [31:0] grow_window(logic [31:0] w, logic [63:0] inc);
    logic [63:0] sum;
    sum = {32'd0, w} + inc;
    return (sum > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
  endfunction

  function automatic logic [31:0] halved_threshold(logic [31:0] w);
    logic [31:0] half;
    half = {1'b0, w[31:1]};
    return (half < 32'(2 * OneWide)) ? 32'(2 * OneWide) : half;
  endfunction

  task automatic predict_event(input logic [1:0] f, input logic [30:0] ack);
    tcwc_pkg::expl_e ex;
    logic [31:0]     prior;
    logic [63:0]     inc;
    cw_result_t      r;
    if (f != tcwc_pkg::FuncNone) begin
      events = events + 32'd1;
      ex = tcwc_pkg::ExDupWait;
      case (f)
        tcwc_pkg::FuncAck: begin
          dups = 2'd0;
          if (cur_phase == tcwc_pkg::PhSlowStart) begin
            cwnd = grow_window(cwnd, OneWide);
            if (cwnd >= ssthresh) cur_phase = tcwc_pkg::PhAvoid;
            ex = tcwc_pkg::ExSsGrow;
          end else if (cur_phase == tcwc_pkg::PhAvoid) begin
            inc = (cwnd == 32'd0) ? 64'h0000_0000_FFFF_FFFF
                                  : (64'd1 << (2 * tcwc_pkg::FracBits)) / {32'd0, cwnd};
            cwnd = grow_window(cwnd, inc);
            ex = tcwc_pkg::ExCaGrow;
          end else if (variant == tcwc_pkg::AlgNewReno && {1'b0, ack} < recover_pt) begin
            cwnd = grow_window(cwnd, OneWide);
            ex = tcwc_pkg::ExPartial;
          end else begin
            cwnd = ssthresh;
            cur_phase = tcwc_pkg::PhAvoid;
            ex = tcwc_pkg::ExFullExit;
          end
        end
        tcwc_pkg::FuncDupAck: begin
          if (dups != 2'd3) dups = dups + 2'd1;
          if (dups == 2'd3) begin
            prior = cwnd;
            ssthresh = halved_threshold(cwnd);
            if (variant == tcwc_pkg::AlgTahoe) begin
              cwnd = 32'(OneWide);
              cur_phase = tcwc_pkg::PhSlowStart;
              ex = tcwc_pkg::ExTahoe;
            end else begin
              if (variant == tcwc_pkg::AlgNewReno) begin
                recover_pt = {1'b0, ack} + (prior >> tcwc_pkg::FracBits);
                ex = tcwc_pkg::ExNewRenoFr;
              end else begin
                ex = tcwc_pkg::ExRenoFr;
              end
              cwnd = grow_window(ssthresh, 3 * OneWide);
              cur_phase = tcwc_pkg::PhRecovery;
            end
          end
        end
        default: begin
          ssthresh = halved_threshold(cwnd);
          cwnd = 32'(OneWide);
          dups = 2'd0;
          cur_phase = tcwc_pkg::PhSlowStart;
          ex = tcwc_pkg::ExTimeout;
        end
      endcase
      r.window      = cwnd;
      r.threshold   = ssthresh;
      r.phase       = cur_phase;
      r.event_count = events;
      r.explanation = ex;
      predicted_q.push_back(r);
    end
  endtask

  task automatic check_result();
    cw_result_t r;
    if (predicted_q.size() == 0) begin
      $error("result word with no prediction pending: window %h", window_i);
      fails++;
    end else begin
      r = predicted_q.pop_front();
      checked++;
      seen[r.explanation] = 1'b1;
      if (window_i !== r.window) begin
        $error("window: expected %h, got %h", r.window, window_i);
        fails++;
      end
      if (threshold_i !== r.threshold) begin
        $error("threshold: expected %h, got %h", r.threshold, threshold_i);
        fails++;
      end
      if (phase_i !== r.phase) begin
        $error("phase: expected %0d, got %0d", r.phase, phase_i);
        fails++;
      end
      if (event_count_i !== r.event_count) begin
        $error("event_count: expected %0d, got %0d", r.event_count, event_count_i);
        fails++;
      end
      if (explanation_i !== r.explanation) begin
        $error("explanation: expected %0d, got %0d", r.explanation, explanation_i);
        fails++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      variant    = tcwc_pkg::AlgReno;
      cur_phase  = tcwc_pkg::PhSlowStart;
      cwnd       = 32'(OneWide);
      ssthresh   = 32'(16 * OneWide);
      events     = 32'd0;
      recover_pt = 32'd0;
      dups       = 2'd0;
      fails      = 0;
      checked    = 0;
      seen       = '0;
      predicted_q.delete();
    end else begin
      if (cfg_we_i) variant = tcwc_pkg::alg_e'(cfg_wdata_i);
      if (out_valid_i && out_ready_i) check_result();
      if (in_valid_i && in_ready_i) predict_event(func_i, ack_number_i);
    end
    fail_count_o <= fails;
    pending_o    <= predicted_q.size();
    checked_o    <= checked;
    expl_seen_o  <= seen;
  end

endmodule

// File: test/tcp_congestion_window_control_tb.sv
// Testbench top: event and result traffic, variant changes and the verdict for the controller.
`timescale 1ns / 1ps

module tcp_congestion_window_control_tb;

  localparam int CycleLimit  = 2_000_000;
  localparam int DrainCycles = 40;
  localparam int SweepWords  = 40;

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_wdata = 2'd0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [1:0]  func      = 2'd0;
  logic [30:0] ack       = 31'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] window;
  logic [31:0] threshold;
  logic [1:0]  phase;
  logic [31:0] event_count;
  logic [3:0]  explanation;

  int          fails;
  int          pending;
  int          checked;
  logic [8:0]  expl_seen;

  bit          no_idle  = 1'b0;
  bit          tx_burst = 1'b0;
  bit          rx_burst = 1'b0;
  int          words_sent = 0;

  tcp_congestion_window_control uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .func_i        (func),
    .ack_number_i  (ack),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .window_o      (window),
    .threshold_o   (threshold),
    .phase_o       (phase),
    .event_count_o (event_count),
    .explanation_o (explanation)
  );

  tcwc_window_checker window_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .func_i        (func),
    .ack_number_i  (ack),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .window_i      (window),
    .threshold_i   (threshold),
    .phase_i       (phase),
    .event_count_i (event_count),
    .explanation_i (explanation),
    .fail_count_o  (fails),
    .pending_o     (pending),
    .checked_o     (checked),
    .expl_seen_o   (expl_seen)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("tcp_congestion_window_control_tb NOT OK");
    $finish;
  end

  initial begin : result_sink
    int hold;
    int taken;
    taken = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (taken == 300) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      hold = (no_idle || rx_burst) ? 0 : $urandom_range(0, 6);
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
      if (taken % 50 == 0) rx_burst = ($urandom_range(0, 3) == 0);
    end
  end

  task automatic send_word(input tcwc_pkg::func_e f, input logic [30:0] a);
    int gap;
    gap = (no_idle || tx_burst) ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func     <= f;
    ack      <= a;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
    if (words_sent % 64 == 0) tx_burst = ($urandom_range(0, 3) == 0);
  endtask

  task automatic dup_burst(input int n, input logic [30:0] a);
    repeat (n) send_word(tcwc_pkg::FuncDupAck, a);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_variant(input tcwc_pkg::alg_e v);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic random_traffic(input int n_words);
    int              done;
    int              len;
    int              kind;
    int              off;
    logic [30:0]     a;
    tcwc_pkg::func_e f;
    done = 0;
    while (done < n_words) begin
      kind = $urandom_range(0, 9);
      a = 31'($urandom);
      case (kind)
        0, 1, 2: begin
          len = $urandom_range(1, 8);
          repeat (len) send_word(tcwc_pkg::FuncAck, 31'($urandom));
          done += len;
        end
        3, 4, 5: begin
          // Duplicate run, then acks at or below the duplicate number, then a likely full ack.
          len = $urandom_range(1, 5);
          dup_burst(len, a);
          done += len;
          len = $urandom_range(0, 6);
          repeat (len) begin
            off = $urandom_range(0, 64);
            send_word(tcwc_pkg::FuncAck, (a >= 31'(off)) ? a - 31'(off) : 31'd0);
          end
          send_word(tcwc_pkg::FuncAck,
                    ($urandom_range(0, 1) == 1) ? 31'h7FFF_FFFF : 31'($urandom));
          done += len + 1;
        end
        6: begin
          send_word(tcwc_pkg::FuncTimeout, a);
          done++;
        end
        7: send_word(tcwc_pkg::FuncNone, a);
        8: begin
          send_word(tcwc_pkg::FuncDupAck, a);
          send_word(tcwc_pkg::func_e'($urandom_range(0, 2)), a);
          done += 2;
        end
        default: begin
          f = tcwc_pkg::func_e'($urandom_range(0, 3));
          send_word(f, a);
          if (f != tcwc_pkg::FuncNone) done++;
        end
      endcase
    end
  endtask

  initial begin : stimulus
    int waited;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_variant(tcwc_pkg::AlgNewReno);
    send_word(tcwc_pkg::FuncAck, 31'd0);
    send_word(tcwc_pkg::FuncAck, 31'h7FFF_FFFF);
    // The recovery point lands above the largest ack number.
    dup_burst(3, 31'h7FFF_FFFF);
    send_word(tcwc_pkg::FuncAck, 31'h7FFF_FFFF);
    send_word(tcwc_pkg::FuncAck, 31'd0);
    dup_burst(4, 31'd0);
    send_word(tcwc_pkg::FuncNone, 31'h7FFF_FFFF);
    send_word(tcwc_pkg::FuncTimeout, 31'h7FFF_FFFF);
    write_variant(tcwc_pkg::AlgTahoe);
    dup_burst(4, 31'h2AAA_AAAA);
    send_word(tcwc_pkg::FuncAck, 31'h5555_5555);
    write_variant(tcwc_pkg::AlgSpare);
    dup_burst(3, 31'd0);
    send_word(tcwc_pkg::FuncAck, 31'd0);
    send_word(tcwc_pkg::FuncAck, 31'd1);
    write_variant(tcwc_pkg::AlgReno);
    dup_burst(3, 31'd9);
    send_word(tcwc_pkg::FuncAck, 31'd0);
    send_word(tcwc_pkg::FuncTimeout, 31'd0);

    for (int i = 0; i < 8; i++) begin
      write_variant(tcwc_pkg::alg_e'((i * 3) % 4));
      random_traffic(145);
    end

    // A run of partial acks in fast recovery grows the window one packet per word,
    // then a second cut, a full ack and the reciprocal increase follow.
    write_variant(tcwc_pkg::AlgNewReno);
    no_idle = 1'b1;
    dup_burst(3, 31'h7FFF_0000);
    repeat (SweepWords) send_word(tcwc_pkg::FuncAck, 31'($urandom_range(0, 32'h7FFE_FFFF)));
    dup_burst(3, 31'd0);
    send_word(tcwc_pkg::FuncAck, 31'h7FFF_FFFF);
    repeat (6) send_word(tcwc_pkg::FuncAck, 31'($urandom));
    send_word(tcwc_pkg::FuncTimeout, 31'($urandom));
    no_idle = 1'b0;

    in_valid <= 1'b0;
    waited = 0;
    @(posedge clk);
    while (pending != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d event words (%0d in the recovery sweep), checked %0d results.",
             words_sent, SweepWords, checked);
    $display("All four variant codes were used; explanation codes seen: %b.", expl_seen);
    if (fails == 0 && pending == 0) begin
      $display("tcp_congestion_window_control_tb OK");
    end else begin
      $display("tcp_congestion_window_control_tb NOT OK");
    end
    $finish;
  end

endmodule

// File: files.f
src/tcwc_pkg.sv
src/tcp_congestion_window_control.sv
test/tcwc_window_checker.sv
test/tcp_congestion_window_control_tb.sv
